>>> rtl/wosf_pkg.sv
// ----------------------------------------------------------------------------
// wosf_pkg: shared types and constants
// Field widths, fixed-point shifts, control FSM states and the structs that
// pass between the modules of the origin slope fit unit.
// ----------------------------------------------------------------------------
package wosf_pkg;

    localparam int SPEED_W    = 16;
    localparam int POWER_W    = 16;
    localparam int SLOPE_W    = 32;
    localparam int POINTS_W   = 3;
    // Q.6 product over Q.8 square gives Q.-2; Q16.16 wants 18 more bits
    localparam int FRAC_SHIFT = 18;
    localparam int QUOT_W     = 32;
    localparam int HI_SHIFT   = QUOT_W - FRAC_SHIFT;
    localparam int STEP_CNT_W = $clog2(QUOT_W);

    localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DRAIN,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_mac_ctl;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic               zero_den;
        logic               sat;
    } t_fit_res;

endpackage

>>> rtl/wosf_if.sv
// ----------------------------------------------------------------------------
// wosf_if: stream interfaces
// Valid/ready channels for the sample pairs coming in and the fit results
// going out.
// ----------------------------------------------------------------------------
interface wosf_in_if;
    logic                              valid;
    logic                              ready;
    logic        [wosf_pkg::SPEED_W-1:0] speed;
    logic signed [wosf_pkg::POWER_W-1:0] power;

    modport source (output valid, output speed, output power, input ready);
    modport sink   (input valid, input speed, input power, output ready);
endinterface

interface wosf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wosf_pkg::SLOPE_W-1:0]  slope;
    logic        [wosf_pkg::POINTS_W-1:0] points_used;
    logic                                zero_denominator;
    logic                                saturated;

    modport source (output valid, output slope, output points_used,
                    output zero_denominator, output saturated, input ready);
    modport sink   (input valid, input slope, input points_used,
                    input zero_denominator, input saturated, output ready);
endinterface

>>> rtl/wosf_cell.sv
// ----------------------------------------------------------------------------
// wosf_cell: one window cell
// Holds one speed/power pair and takes its neighbour's pair when enabled.
// ----------------------------------------------------------------------------
module wosf_cell (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic        [wosf_pkg::SPEED_W-1:0] i_speed,
    input  logic signed [wosf_pkg::POWER_W-1:0] i_power,
    output logic        [wosf_pkg::SPEED_W-1:0] o_speed,
    output logic signed [wosf_pkg::POWER_W-1:0] o_power
);

    logic        [wosf_pkg::SPEED_W-1:0] r_speed;
    logic signed [wosf_pkg::POWER_W-1:0] r_power;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_speed <= i_speed;
            r_power <= i_power;
        end
    end

    assign o_speed = r_speed;
    assign o_power = r_power;

endmodule

>>> rtl/wosf_mac.sv
// ----------------------------------------------------------------------------
// wosf_mac: product and square accumulator
// Registers speed*power and speed^2 of the pair leaving the chain, then adds
// them into the numerator and denominator sums.
// ----------------------------------------------------------------------------
module wosf_mac #(
    parameter int ACC_W = 36
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wosf_pkg::t_mac_ctl                  i_ctl,
    input  logic        [wosf_pkg::SPEED_W-1:0] i_speed,
    input  logic signed [wosf_pkg::POWER_W-1:0] i_power,
    output logic signed [ACC_W-1:0]             o_num,
    output logic        [ACC_W-1:0]             o_den
);

    localparam int PROD_W = wosf_pkg::SPEED_W + wosf_pkg::POWER_W;
    localparam int SQ_W   = 2 * wosf_pkg::SPEED_W;

    logic                     r_sample;
    logic signed [PROD_W-1:0] r_prod;
    logic        [SQ_W-1:0]   r_sq;
    logic signed [ACC_W-1:0]  r_num;
    logic        [ACC_W-1:0]  r_den;
    logic signed [PROD_W:0]   prod_full;

    // speed is unsigned: widen with a zero sign bit before the signed multiply
    assign prod_full = $signed({1'b0, i_speed}) * i_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= 1'b0;
        end else begin
            r_sample <= i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[PROD_W-1:0];
        r_sq   <= i_speed * i_speed;
        if (i_ctl.clear) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_sample) begin
            r_num <= r_num + ACC_W'(r_prod);
            r_den <= r_den + ACC_W'(r_sq);
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

>>> rtl/wosf_div.sv
// ----------------------------------------------------------------------------
// wosf_div: saturating slope divider
// Restoring division of |num| * 2^18 by den, one quotient bit per cycle,
// with early overflow detection and Q16.16 saturation.
// ----------------------------------------------------------------------------
module wosf_div #(
    parameter int ACC_W = 36
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic        [ACC_W-1:0] i_den,
    output logic                    o_done,
    output wosf_pkg::t_fit_res      o_res
);

    localparam int QW = wosf_pkg::QUOT_W;
    localparam int HS = wosf_pkg::HI_SHIFT;
    localparam int CW = wosf_pkg::STEP_CNT_W;

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [ACC_W-1:0]  r_den;
    logic [ACC_W-1:0]  r_rem;
    logic [QW-1:0]     r_lo;
    logic [QW-1:0]     r_quot;
    wosf_pkg::t_fit_res r_res;

    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  hi;
    logic [ACC_W:0]    trial;
    logic              ge;
    logic              quot_sat;
    logic [QW-1:0]     quot_neg;

    assign mag   = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign hi    = mag >> HS;
    assign trial = {r_rem, r_lo[QW-1]};
    assign ge    = trial >= {1'b0, r_den};

    assign quot_neg = -r_quot;
    assign quot_sat = r_neg ? (r_quot > wosf_pkg::SLOPE_MIN) : r_quot[QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                // zero denominator and quotient beyond 32 bits finish at once
                if (i_den == '0 || hi >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[ACC_W-1];
            r_den  <= i_den;
            r_rem  <= hi;
            r_lo   <= {mag[HS-1:0], {wosf_pkg::FRAC_SHIFT{1'b0}}};
            r_quot <= '0;
            if (i_den == '0) begin
                r_res.slope    <= '0;
                r_res.zero_den <= 1'b1;
                r_res.sat      <= 1'b0;
            end else begin
                r_res.slope    <= i_num[ACC_W-1] ? wosf_pkg::SLOPE_MIN
                                                 : wosf_pkg::SLOPE_MAX;
                r_res.zero_den <= 1'b0;
                r_res.sat      <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem  <= ge ? ACC_W'(trial - {1'b0, r_den}) : trial[ACC_W-1:0];
            r_lo   <= {r_lo[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end else if (r_fin) begin
            r_res.zero_den <= 1'b0;
            r_res.sat      <= quot_sat;
            if (quot_sat) begin
                r_res.slope <= r_neg ? wosf_pkg::SLOPE_MIN : wosf_pkg::SLOPE_MAX;
            end else begin
                r_res.slope <= r_neg ? quot_neg : r_quot;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> rtl/windowed_origin_slope_fit_unit.sv
// ----------------------------------------------------------------------------
// windowed_origin_slope_fit_unit: sliding window slope through the origin
// Flow: after an input transfer the chain makes a full rotation with its tail
// feeding the MAC, the MAC drains, the divider starts and runs at one bit per
// cycle, and the result is loaded; the divider ends at once on a zero
// denominator or a clipped quotient. A new pair is taken only in idle, so
// fits do not overlap; a stalled output holds the unit before the load.
// Reset (synchronous, active low) empties the window and the output register.
// ----------------------------------------------------------------------------
module windowed_origin_slope_fit_unit #(
    parameter int WINDOW = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wosf_in_if.sink          i_in,
    wosf_out_if.source       o_out
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int ACC_W = 32 + $clog2(WINDOW) + 1;

    wosf_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]   r_filled, n_filled;
    logic               r_out_valid, n_out_valid;
    wosf_pkg::t_fit_res r_out_res;
    logic [wosf_pkg::POINTS_W-1:0] r_out_points;

    logic                                cell_en;
    logic        [wosf_pkg::SPEED_W-1:0] head_speed;
    logic signed [wosf_pkg::POWER_W-1:0] head_power;
    logic        [wosf_pkg::SPEED_W-1:0] cell_speed [WINDOW];
    logic signed [wosf_pkg::POWER_W-1:0] cell_power [WINDOW];

    wosf_pkg::t_mac_ctl mac_ctl;
    logic signed [ACC_W-1:0] mac_num;
    logic        [ACC_W-1:0] mac_den;
    logic               div_start;
    logic               div_done;
    wosf_pkg::t_fit_res div_res;

    logic               load_out;
    logic [CNT_W:0]     step_sum;
    logic [CNT_W+wosf_pkg::POINTS_W-1:0] filled_ext;

    // cell k of the chain reaches the tail at step WINDOW-1-k; only the
    // newest r_filled cells hold written pairs
    assign step_sum = {1'b0, r_step} + {1'b0, r_filled};
    assign filled_ext = {{wosf_pkg::POINTS_W{1'b0}}, r_filled};

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_filled    = r_filled;
        n_out_valid = r_out_valid;
        i_in.ready  = 1'b0;
        cell_en     = 1'b0;
        head_speed  = cell_speed[WINDOW-1];
        head_power  = cell_power[WINDOW-1];
        mac_ctl     = '0;
        div_start   = 1'b0;
        load_out    = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wosf_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    cell_en       = 1'b1;
                    head_speed    = i_in.speed;
                    head_power    = i_in.power;
                    mac_ctl.clear = 1'b1;
                    n_step        = '0;
                    if (r_filled != CNT_W'(WINDOW)) begin
                        n_filled = r_filled + 1'b1;
                    end
                    n_state = wosf_pkg::ST_ROTATE;
                end
            end
            wosf_pkg::ST_ROTATE: begin
                cell_en        = 1'b1;
                mac_ctl.sample = step_sum >= (CNT_W + 1)'(WINDOW);
                n_step         = r_step + 1'b1;
                if (r_step == CNT_W'(WINDOW - 1)) begin
                    n_state = wosf_pkg::ST_DRAIN;
                end
            end
            wosf_pkg::ST_DRAIN: begin
                // last registered product lands in the sums here
                n_state = wosf_pkg::ST_START;
            end
            wosf_pkg::ST_START: begin
                div_start = 1'b1;
                n_state   = wosf_pkg::ST_DIVIDE;
            end
            wosf_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    n_state = wosf_pkg::ST_FINISH;
                end
            end
            wosf_pkg::ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = wosf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wosf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wosf_pkg::ST_IDLE;
            r_step      <= '0;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_res    <= div_res;
            r_out_points <= filled_ext[wosf_pkg::POINTS_W-1:0];
        end
    end

    // chain: new pair enters cell 0 on a transfer; during the fit the chain
    // rotates, tail feeding the MAC and wrapping back to cell 0
    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == 0) begin : g_head
                wosf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_en    (cell_en),
                    .i_speed (head_speed),
                    .i_power (head_power),
                    .o_speed (cell_speed[g]),
                    .o_power (cell_power[g])
                );
            end else begin : g_body
                wosf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_en    (cell_en),
                    .i_speed (cell_speed[g-1]),
                    .i_power (cell_power[g-1]),
                    .o_speed (cell_speed[g]),
                    .o_power (cell_power[g])
                );
            end
        end
    endgenerate

    wosf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_speed (cell_speed[WINDOW-1]),
        .i_power (cell_power[WINDOW-1]),
        .o_num   (mac_num),
        .o_den   (mac_den)
    );

    wosf_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mac_num),
        .i_den   (mac_den),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.slope            = r_out_res.slope;
    assign o_out.points_used      = r_out_points;
    assign o_out.zero_denominator = r_out_res.zero_den;
    assign o_out.saturated        = r_out_res.sat;

endmodule

>>> tb/sv/tb_windowed_origin_slope_fit_unit.sv
// ----------------------------------------------------------------------------
// tb_windowed_origin_slope_fit_unit: origin slope fit unit testbench
// Drives (speed, power) pairs through the input channel and keeps a shadow
// window of the last WINDOW pairs. Every transfer produces a predicted
// Q16.16 slope, point count and flags. Each result transfer is compared
// with the oldest prediction. Both channels stall at random, except in
// the final back-to-back phase.
// ----------------------------------------------------------------------------
module tb_windowed_origin_slope_fit_unit;

    localparam int WINDOW     = 5;
    localparam int IDLE_LIMIT = 4000;

    typedef logic        [wosf_pkg::SPEED_W-1:0] t_speed;
    typedef logic signed [wosf_pkg::POWER_W-1:0] t_power;

    typedef struct packed {
        logic signed [wosf_pkg::SLOPE_W-1:0]  slope;
        logic        [wosf_pkg::POINTS_W-1:0] points_used;
        logic                                 zero_den;
        logic                                 sat;
    } t_fit;

    logic i_clk;
    logic i_rst_n;

    wosf_in_if  in_bus();
    wosf_out_if out_bus();

    windowed_origin_slope_fit_unit #(.WINDOW(WINDOW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Shadow copy of the sample window
    bit        [wosf_pkg::SPEED_W-1:0] win_speed [WINDOW];
    bit signed [wosf_pkg::POWER_W-1:0] win_power [WINDOW];
    int                                wr_slot;
    int                                fill_cnt;

    t_fit pending_fits[$];
    int   mismatches;
    int   idle_cycles;
    bit   idle_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stores the pair, then fits sum(s*p)/sum(s*s) over the filled entries
    function automatic t_fit fit_window_slope(input t_speed spd, input t_power pwr);
        t_fit                 r;
        longint               num;
        longint unsigned      den;
        longint unsigned      mag;
        longint unsigned      quo;
        longint               s;
        longint               p;
        win_speed[wr_slot] = spd;
        win_power[wr_slot] = pwr;
        wr_slot = (wr_slot + 1) % WINDOW;
        if (fill_cnt < WINDOW)
            fill_cnt++;
        num = 0;
        den = 0;
        for (int k = 0; k < fill_cnt; k++) begin
            s = longint'(win_speed[k]);
            p = longint'(win_power[k]);
            num += s * p;
            den += longint'(s * s);
        end
        r.points_used = fill_cnt[wosf_pkg::POINTS_W-1:0];
        r.sat         = 1'b0;
        r.zero_den    = 1'b0;
        if (den == 0) begin
            r.zero_den = 1'b1;
            r.slope    = '0;
        end else if (num >= 0) begin
            quo = (longint'(num) << wosf_pkg::FRAC_SHIFT) / den;
            if (quo > 64'h7FFF_FFFF) begin
                quo   = 64'h7FFF_FFFF;
                r.sat = 1'b1;
            end
            r.slope = quo[wosf_pkg::SLOPE_W-1:0];
        end else begin
            mag = -num;
            quo = (mag << wosf_pkg::FRAC_SHIFT) / den;
            // exactly -2^31 still fits, anything beyond clips
            if (quo > 64'h8000_0000) begin
                quo   = 64'h8000_0000;
                r.sat = 1'b1;
            end
            quo     = 64'd0 - quo;
            r.slope = quo[wosf_pkg::SLOPE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_speed rand_speed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_speed'($urandom_range(1, 15));
            3:       return t_speed'($urandom_range(0, 255));
            default: return t_speed'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_power rand_power();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return t_power'(int'($urandom_range(0, 31)) - 16);
            default: return t_power'($urandom);
        endcase
    endfunction

    // Returns at the edge of the transfer with valid still high, so the
    // next call can follow back-to-back without touching valid twice.
    task automatic send_pair(input t_speed spd, input t_power pwr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_bus.speed <= spd;
        in_bus.power <= pwr;
        in_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_fits.push_back(fit_window_slope(spd, pwr));
    endtask

    task automatic wait_for_fits();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_fits.size() != 0);
    endtask

    // Window fill from empty, zero denominator, clipping both ways,
    // the exact negative bound and full-scale samples
    task automatic test_directed();
        send_pair(16'd0, 16'sh7FFF);
        send_pair(16'd0, 16'sh8000);
        send_pair(16'd1, 16'sh7FFF);
        send_pair(16'd1, 16'sh8000);
        send_pair(16'hFFFF, 16'sh7FFF);
        repeat (WINDOW) send_pair(16'd0, t_power'($urandom));
        send_pair(16'd1, 16'sh8000);
        repeat (WINDOW - 1) send_pair(16'd0, 16'sd0);
        send_pair(16'd1, -16'sd8192);
        send_pair(16'd1, 16'sd8192);
        repeat (4) send_pair(16'hFFFF, 16'sh8000);
        wait_for_fits();
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_pair(rand_speed(), rand_power());
    endtask

    // Runs of zero speed flush the window; short bursts in between
    task automatic test_zero_speed_runs(input int runs);
        repeat (runs) begin
            repeat ($urandom_range(WINDOW, WINDOW + 2)) send_pair('0, rand_power());
            repeat ($urandom_range(1, 3))
                send_pair(t_speed'($urandom_range(0, 3)), rand_power());
        end
    endtask

    // Tiny speeds against large powers push the quotient to the bounds
    task automatic test_clipping(input int n);
        repeat (n) send_pair(t_speed'($urandom_range(0, 3)), rand_power());
    endtask

    task automatic test_drain_pause(input int bursts);
        repeat (bursts) begin
            repeat ($urandom_range(1, WINDOW)) send_pair(rand_speed(), rand_power());
            wait_for_fits();
        end
    endtask

    task automatic test_back_to_back(input int n);
        idle_on = 1'b0;
        repeat (n) send_pair(rand_speed(), rand_power());
    endtask

    // Result side: random stall bursts while idling is enabled
    initial begin
        int stall_left;
        stall_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_fit want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_fits.size() == 0) begin
                $error("result transfer with nothing pending: slope %0d", out_bus.slope);
                mismatches++;
            end else begin
                want = pending_fits.pop_front();
                if (out_bus.slope !== want.slope) begin
                    $error("slope: expected %0d, got %0d", want.slope, out_bus.slope);
                    mismatches++;
                end
                if (out_bus.points_used !== want.points_used) begin
                    $error("points_used: expected %0d, got %0d",
                           want.points_used, out_bus.points_used);
                    mismatches++;
                end
                if (out_bus.zero_denominator !== want.zero_den) begin
                    $error("zero_denominator: expected %0b, got %0b",
                           want.zero_den, out_bus.zero_denominator);
                    mismatches++;
                end
                if (out_bus.saturated !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, out_bus.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        mismatches   = 0;
        wr_slot      = 0;
        fill_cnt     = 0;
        idle_on      = 1'b1;
        i_rst_n      <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.speed <= '0;
        in_bus.power <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(500);
        test_zero_speed_runs(20);
        test_clipping(80);
        test_drain_pause(12);
        test_back_to_back(250);

        wait_for_fits();
        repeat (WINDOW + 40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
